### design/isot_pkg.sv
package isot_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int ELEM_W_DEF = 32;

  // Widths fixed by the port list.
  localparam int CNT_W = 5;
  localparam int VAL_W = 32;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_DUP     = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the input word and the match vector
    logic commit;  // update the table and fill the output register
  } ctl_cmd_t;

endpackage

### design/insertion_ordered_set_table.sv
// Insertion-ordered set of distinct values.
// Input channel: in_operation (0 insert, 1 remove) and in_value, with
// in_valid/in_ready. Result channel: out_status, out_count, out_is_empty,
// out_oldest_value and out_newest_value, with out_valid/out_ready; every
// input word yields exactly one result word.
// In the accept cycle all live entries are compared against the value in
// parallel; in the execute state, once the output register is empty or being
// taken, the table is appended to or shifted down and the output register is
// loaded. One word is in flight at a time. The output register lets the next
// word be accepted while a result waits; if the receiver stalls, that second
// word is held until the output register frees, and no further input is taken
// meanwhile.
// cfg_wr_en/cfg_wr_data set the capacity and may only be written while idle.
// Reset empties the set and sets the capacity to 16; entry storage is not
// cleared since only entries below the count are ever read.
module insertion_ordered_set_table #(
  parameter int DEPTH  = isot_pkg::DEPTH_DEF,
  parameter int ELEM_W = isot_pkg::ELEM_W_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [isot_pkg::CNT_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_operation,
  input  logic [isot_pkg::VAL_W-1:0]  in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [isot_pkg::CNT_W-1:0]  out_count,
  output logic                        out_is_empty,
  output logic [isot_pkg::VAL_W-1:0]  out_oldest_value,
  output logic [isot_pkg::VAL_W-1:0]  out_newest_value
);
  import isot_pkg::*;

  ctl_cmd_t cmd;

  isot_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  isot_dp #(
    .DEPTH  (DEPTH),
    .ELEM_W (ELEM_W)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .out_status       (out_status),
    .out_count        (out_count),
    .out_is_empty     (out_is_empty),
    .out_oldest_value (out_oldest_value),
    .out_newest_value (out_newest_value)
  );

endmodule

### design/isot_ctrl.sv
module isot_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output isot_pkg::ctl_cmd_t cmd
);
  import isot_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   load, commit;

  assign in_ready = (state_r == S_IDLE);
  assign load     = in_valid && in_ready;
  // The result may overwrite the output register once it is empty or being taken.
  assign commit   = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (load) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign cmd.load   = load;
  assign cmd.commit = commit;

endmodule

### design/isot_dp.sv
module isot_dp #(
  parameter int DEPTH  = isot_pkg::DEPTH_DEF,
  parameter int ELEM_W = isot_pkg::ELEM_W_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  isot_pkg::ctl_cmd_t          cmd,
  input  logic                        cfg_wr_en,
  input  logic [isot_pkg::CNT_W-1:0]  cfg_wr_data,
  input  logic                        in_operation,
  input  logic [isot_pkg::VAL_W-1:0]  in_value,
  output logic [1:0]                  out_status,
  output logic [isot_pkg::CNT_W-1:0]  out_count,
  output logic                        out_is_empty,
  output logic [isot_pkg::VAL_W-1:0]  out_oldest_value,
  output logic [isot_pkg::VAL_W-1:0]  out_newest_value
);
  import isot_pkg::*;

  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_MAX   = (1 << CNT_W) - 1;
  localparam int DEPTH_LIM = (DEPTH > CNT_MAX) ? CNT_MAX : DEPTH;

  logic [ELEM_W-1:0] entries_r [DEPTH];
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  cap_r;

  // Captured word and per-entry match flags.
  op_t               op_r;
  logic [ELEM_W-1:0] val_r;
  logic [DEPTH-1:0]  match_r;
  logic [DEPTH-1:0]  match_now;
  logic [ELEM_W-1:0] in_elem;

  logic [CNT_W-1:0]  limit;
  logic [CNT_W-1:0]  cnt_m1, rd_cnt;
  logic [IDX_W-1:0]  pos, rd_idx;
  logic              hit, full, ins_do, rm_do, pos_first, pos_last;
  status_t           status;
  logic [ELEM_W-1:0] oldest, newest;

  logic [1:0]        status_r;
  logic [CNT_W-1:0]  count_r;
  logic              empty_r;
  logic [VAL_W-1:0]  oldest_r, newest_r;

  assign in_elem = ELEM_W'(in_value);

  // Every live entry is compared at once; stale entries at or above the count are masked.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_now[i] = (entries_r[i] == in_elem) && (32'(i) < 32'(cnt_r));
    end
  end

  // Live entries are distinct, so at most one flag is set and an OR encode gives its place.
  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      pos = pos | (match_r[i] ? IDX_W'(i) : '0);
    end
  end

  assign limit     = (32'(cap_r) < 32'(DEPTH_LIM)) ? cap_r : CNT_W'(DEPTH_LIM);
  assign hit       = |match_r;
  assign full      = (cnt_r >= limit);
  assign ins_do    = (op_r == OP_INSERT) && !full && !hit;
  assign rm_do     = (op_r == OP_REMOVE) && hit;
  assign cnt_m1    = cnt_r - CNT_W'(1);
  assign pos_first = (pos == '0);
  assign pos_last  = (32'(pos) == 32'(cnt_m1));

  always_comb begin
    if (op_r == OP_INSERT) begin
      status = full ? ST_FULL : (hit ? ST_DUP : ST_DONE);
    end else begin
      status = hit ? ST_DONE : ST_MISSING;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ins_do) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (rm_do) begin
      cnt_nxt = cnt_m1;
    end
  end

  // Newest entry after the operation, read from the table before it changes.
  assign rd_cnt = (rm_do && pos_last) ? (cnt_r - CNT_W'(2)) : cnt_m1;
  assign rd_idx = IDX_W'(rd_cnt);

  always_comb begin
    if (cnt_nxt == '0) begin
      oldest = '0;
      newest = '0;
    end else begin
      if (ins_do && cnt_r == '0) begin
        oldest = val_r;
      end else if (rm_do && pos_first) begin
        oldest = entries_r[1];
      end else begin
        oldest = entries_r[0];
      end
      newest = ins_do ? val_r : entries_r[rd_idx];
    end
  end

  // Table storage: append at the count, or shift every entry from the hit upward down by one.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (ins_do && (32'(cnt_r) == 32'(i))) begin
          entries_r[i] <= val_r;
        end else if (rm_do && (i < DEPTH - 1) && (32'(pos) <= 32'(i))) begin
          entries_r[i] <= entries_r[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      cap_r <= CAP_RESET;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (cmd.commit) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= op_t'(in_operation);
      val_r   <= in_elem;
      match_r <= match_now;
    end
    if (cmd.commit) begin
      status_r <= status;
      count_r  <= cnt_nxt;
      empty_r  <= (cnt_nxt == '0);
      oldest_r <= VAL_W'(oldest);
      newest_r <= VAL_W'(newest);
    end
  end

  assign out_status       = status_r;
  assign out_count        = count_r;
  assign out_is_empty     = empty_r;
  assign out_oldest_value = oldest_r;
  assign out_newest_value = newest_r;

endmodule

### design/isot_chk.sv
module isot_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  out_status,
  input logic [isot_pkg::CNT_W-1:0]  out_count,
  input logic                        out_is_empty,
  input logic [isot_pkg::VAL_W-1:0]  out_oldest_value,
  input logic [isot_pkg::VAL_W-1:0]  out_newest_value
);
  import isot_pkg::*;

  // A held result word is not dropped.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // Only one word is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a word is in flight");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_count == '0)))
    else $error("empty flag disagrees with count");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> (out_oldest_value == '0) && (out_newest_value == '0))
    else $error("empty set reports nonzero values");

  // A duplicate can only be found in a set that holds something.
  a_dup_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_DUP) |-> !out_is_empty)
    else $error("duplicate reported on an empty set");

endmodule

bind insertion_ordered_set_table isot_chk u_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_count        (out_count),
  .out_is_empty     (out_is_empty),
  .out_oldest_value (out_oldest_value),
  .out_newest_value (out_newest_value)
);
